[hw/rtl/pidc_pkg.sv]
`default_nettype none

package pidc_pkg;

   // Field widths
   localparam int GainW  = 32;
   localparam int DataW  = 16;
   localparam int TimeW  = 32;
   localparam int FracW  = 16;
   localparam int AccW   = DataW + FracW;
   localparam int ErrW   = DataW + 1;
   localparam int ProdW  = GainW + ErrW;
   localparam int IntegW = ProdW + 1;
   localparam int SumW   = ProdW + 2;
   localparam int ShW    = SumW - FracW;

   // Configuration port
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   typedef enum logic [CsrIdxW-1:0] {
      REG_GAIN_P      = 3'd0,
      REG_GAIN_I      = 3'd1,
      REG_GAIN_D      = 3'd2,
      REG_LIMIT_LOW   = 3'd3,
      REG_LIMIT_HIGH  = 3'd4,
      REG_PERIOD      = 3'd5,
      REG_REVERSE     = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_COMPUTE = 1'b0,
      KIND_MODE    = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [GainW-1:0] gain_p;
      logic signed [GainW-1:0] gain_i;
      logic signed [GainW-1:0] gain_d;
      logic signed [DataW-1:0] limit_low;
      logic signed [DataW-1:0] limit_high;
      logic [DataW-1:0]        sample_period_ms;
      logic                    reverse_acting;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:           '0,
      gain_i:           '0,
      gain_d:           '0,
      limit_low:        16'sd0,
      limit_high:       16'sd255,
      sample_period_ms: 16'd100,
      reverse_acting:   1'b0
   };

   typedef struct packed {
      kind_type                kind;
      logic [TimeW-1:0]        now_ms;
      logic signed [DataW-1:0] measurement;
      logic signed [DataW-1:0] setpoint;
      logic                    auto_request;
      logic signed [DataW-1:0] manual_drive;
   } item_type;

   typedef struct packed {
      logic signed [AccW-1:0]  integral_acc;
      logic signed [DataW-1:0] prev_measurement;
      logic [TimeW-1:0]        prev_time;
      logic                    auto_mode;
      logic signed [DataW-1:0] held_drive;
   } state_type;

   typedef struct packed {
      logic signed [DataW-1:0] drive;
      logic                    computed;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/pid_controller_step.sv]
// PID controller step with derivative on measurement and a clamped integral.
// Each request transaction is either a compute (kind 0) or a mode change
// (kind 1) and yields exactly one response transaction carrying the current
// drive and a flag telling whether a new PID computation took place. Gains
// are signed Q16.16, already scaled to the sample period; limit_low and
// limit_high clamp both the drive and the integral. The block takes one
// transaction per clock cycle while the response is not stalled; an accepted
// transaction is held in the request register, then passes through the
// datapath into the response register. The rate is set by the state loop
// (integral, previous measurement, previous time, mode, drive), which is
// updated in that single datapath pass so the next transaction sees it at
// once. A stalled response holds while one further request is still
// taken into the request register. Write the configuration port only while
// no transaction is in flight.
`default_nettype none

module pid_controller_step (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_kind,
   input  wire logic [pidc_pkg::TimeW-1:0]       req_now_ms,
   input  wire logic signed [pidc_pkg::DataW-1:0] req_measurement,
   input  wire logic signed [pidc_pkg::DataW-1:0] req_setpoint,
   input  wire logic                             req_auto_request,
   input  wire logic signed [pidc_pkg::DataW-1:0] req_manual_drive,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [pidc_pkg::DataW-1:0]     rsp_drive,
   output logic                                  rsp_computed,

   input  wire logic                             csr_write,
   input  wire logic [pidc_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [pidc_pkg::CsrDataW-1:0]    csr_wdata
);

   pidc_pkg::cfg_type    cfg;

   // Request register
   pidc_pkg::item_type   item_ff;
   pidc_pkg::item_type   item_in;
   logic                 item_valid_ff;
   logic                 item_valid_in;

   // Controller state
   pidc_pkg::state_type  state_ff;
   pidc_pkg::state_type  state_in;
   pidc_pkg::state_type  state_next;

   // Response register
   pidc_pkg::result_type result;
   pidc_pkg::result_type rsp_ff;
   pidc_pkg::result_type rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   logic                 req_fire;
   logic                 advance;

   pidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidc_core u_core (
      .cfg        (cfg),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   // Advance the held transaction whenever the response register is free or
   // being emptied in this cycle.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      item_in.kind         = pidc_pkg::kind_type'(req_kind);
      item_in.now_ms       = req_now_ms;
      item_in.measurement  = req_measurement;
      item_in.setpoint     = req_setpoint;
      item_in.auto_request = req_auto_request;
      item_in.manual_drive = req_manual_drive;
   end

   always_comb begin
      if (req_fire) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   // Commit the state only when the transaction moves to the response side.
   assign state_in = advance ? state_next : state_ff;
   assign rsp_in   = advance ? result : rsp_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_drive    = rsp_ff.drive;
   assign rsp_computed = rsp_ff.computed;

endmodule

`default_nettype wire

[hw/rtl/pidc_csr.sv]
`default_nettype none

module pidc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [pidc_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [pidc_pkg::CsrDataW-1:0]    csr_wdata,
   output pidc_pkg::cfg_type                     cfg
);

   pidc_pkg::cfg_type cfg_ff;
   pidc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (pidc_pkg::csr_index_type'(csr_index))
            pidc_pkg::REG_GAIN_P: begin
               cfg_in.gain_p = csr_wdata[pidc_pkg::GainW-1:0];
            end
            pidc_pkg::REG_GAIN_I: begin
               cfg_in.gain_i = csr_wdata[pidc_pkg::GainW-1:0];
            end
            pidc_pkg::REG_GAIN_D: begin
               cfg_in.gain_d = csr_wdata[pidc_pkg::GainW-1:0];
            end
            pidc_pkg::REG_LIMIT_LOW: begin
               cfg_in.limit_low = csr_wdata[pidc_pkg::DataW-1:0];
            end
            pidc_pkg::REG_LIMIT_HIGH: begin
               cfg_in.limit_high = csr_wdata[pidc_pkg::DataW-1:0];
            end
            pidc_pkg::REG_PERIOD: begin
               cfg_in.sample_period_ms = csr_wdata[pidc_pkg::DataW-1:0];
            end
            pidc_pkg::REG_REVERSE: begin
               cfg_in.reverse_acting = csr_wdata[0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pidc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/pidc_core.sv]
`default_nettype none

module pidc_core (
   input  wire pidc_pkg::cfg_type    cfg,
   input  wire pidc_pkg::item_type   item,
   input  wire pidc_pkg::state_type  state,
   output pidc_pkg::state_type       state_next,
   output pidc_pkg::result_type      result
);

   localparam int DataW  = pidc_pkg::DataW;
   localparam int FracW  = pidc_pkg::FracW;
   localparam int AccW   = pidc_pkg::AccW;
   localparam int ErrW   = pidc_pkg::ErrW;
   localparam int ProdW  = pidc_pkg::ProdW;
   localparam int IntegW = pidc_pkg::IntegW;
   localparam int SumW   = pidc_pkg::SumW;
   localparam int ShW    = pidc_pkg::ShW;
   localparam int TimeW  = pidc_pkg::TimeW;
   localparam int GainW  = pidc_pkg::GainW;

   logic signed [GainW-1:0]  gain_p, gain_i, gain_d;
   logic signed [DataW-1:0]  lim_lo, lim_hi;
   logic signed [AccW-1:0]   lim_lo_q, lim_hi_q;
   logic signed [ErrW-1:0]   meas_x, setp_x, prev_x;
   logic signed [ErrW-1:0]   err, dmeas;
   logic signed [ProdW-1:0]  prod_p, prod_i, prod_d;
   logic signed [AccW-1:0]   acc;
   logic signed [IntegW-1:0] integ_raw;
   logic signed [AccW-1:0]   integ;
   logic signed [SumW-1:0]   sum;
   logic signed [ShW-1:0]    shifted;
   logic signed [DataW-1:0]  drv;
   logic signed [AccW-1:0]   manual_q;
   logic signed [AccW-1:0]   manual_integ;
   logic [TimeW-1:0]         elapsed;
   logic                     due;

   assign gain_p   = cfg.gain_p;
   assign gain_i   = cfg.gain_i;
   assign gain_d   = cfg.gain_d;
   assign lim_lo   = cfg.limit_low;
   assign lim_hi   = cfg.limit_high;
   assign lim_lo_q = {lim_lo, {FracW{1'b0}}};
   assign lim_hi_q = {lim_hi, {FracW{1'b0}}};
   assign acc      = state.integral_acc;

   assign meas_x = {item.measurement[DataW-1], item.measurement};
   assign setp_x = {item.setpoint[DataW-1], item.setpoint};
   assign prev_x = {state.prev_measurement[DataW-1], state.prev_measurement};

   // Reverse action negates every gain; negate the 17-bit operands instead,
   // which is exact since both differences stay within +/-65535.
   assign err   = cfg.reverse_acting ? (meas_x - setp_x) : (setp_x - meas_x);
   assign dmeas = cfg.reverse_acting ? (prev_x - meas_x) : (meas_x - prev_x);

   assign prod_p = ProdW'(gain_p) * ProdW'(err);
   assign prod_i = ProdW'(gain_i) * ProdW'(err);
   assign prod_d = ProdW'(gain_d) * ProdW'(dmeas);

   assign integ_raw = IntegW'(acc) + IntegW'(prod_i);

   // Clamp: above high wins over below low, also with inverted limits
   always_comb begin
      if (integ_raw > IntegW'(lim_hi_q)) begin
         integ = lim_hi_q;
      end else if (integ_raw < IntegW'(lim_lo_q)) begin
         integ = lim_lo_q;
      end else begin
         integ = integ_raw[AccW-1:0];
      end
   end

   assign sum     = SumW'(prod_p) + SumW'(integ) - SumW'(prod_d);
   assign shifted = sum[SumW-1:FracW];

   always_comb begin
      if (shifted > ShW'(lim_hi)) begin
         drv = lim_hi;
      end else if (shifted < ShW'(lim_lo)) begin
         drv = lim_lo;
      end else begin
         drv = shifted[DataW-1:0];
      end
   end

   assign manual_q = {item.manual_drive, {FracW{1'b0}}};

   always_comb begin
      if (manual_q > lim_hi_q) begin
         manual_integ = lim_hi_q;
      end else if (manual_q < lim_lo_q) begin
         manual_integ = lim_lo_q;
      end else begin
         manual_integ = manual_q;
      end
   end

   assign elapsed = item.now_ms - state.prev_time;
   assign due     = elapsed >= TimeW'(cfg.sample_period_ms);

   always_comb begin
      state_next      = state;
      result.computed = 1'b0;
      case (item.kind)
         pidc_pkg::KIND_MODE: begin
            if (!item.auto_request) begin
               state_next.held_drive = item.manual_drive;
            end else if (!state.auto_mode) begin
               // bumpless entry to automatic
               state_next.held_drive       = item.manual_drive;
               state_next.integral_acc     = manual_integ;
               state_next.prev_measurement = item.measurement;
            end
            state_next.auto_mode = item.auto_request;
         end
         pidc_pkg::KIND_COMPUTE: begin
            if (state.auto_mode && due) begin
               state_next.integral_acc     = integ;
               state_next.held_drive       = drv;
               state_next.prev_measurement = item.measurement;
               state_next.prev_time        = item.now_ms;
               result.computed             = 1'b1;
            end
         end
         default: begin
         end
      endcase
      result.drive = state_next.held_drive;
   end

endmodule

`default_nettype wire
